[sv/dccb_pkg.sv]
`timescale 1ns / 1ps

package dccb_pkg;

  // Fixed-point formats and counter range of the block.
  localparam int MAX_COMMANDS    = 65536;
  localparam int COORD_FRAC_BITS = 8;
  localparam int SCALE_FRAC_BITS = 12;
  localparam int PIX_FRAC_BITS   = COORD_FRAC_BITS + SCALE_FRAC_BITS;

  // Field widths.
  localparam int COORD_W = 24;
  localparam int EDGE_W  = COORD_W + 1;
  localparam int SCALE_W = 16;
  localparam int PROD_W  = EDGE_W + SCALE_W + 1;
  localparam int INT_W   = PROD_W - PIX_FRAC_BITS;
  localparam int PIX_W   = 15;
  localparam int TEX_W   = 16;
  localparam int CNT_W   = $clog2(MAX_COMMANDS);
  localparam int SIZE_W  = CNT_W + 1;

  // Stream word widths.
  localparam int IN_DATA_W  = 8 * COORD_W + TEX_W;
  localparam int OUT_DATA_W = 160;

  // Result queue.
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam logic [1:0] REG_DPI_SCALE    = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  // Configuration reset values.
  localparam logic [SCALE_W-1:0] DPI_SCALE_RESET    = 16'd4096;
  localparam logic [PIX_W-1:0]   FRAME_WIDTH_RESET  = 15'd1920;
  localparam logic [PIX_W-1:0]   FRAME_HEIGHT_RESET = 15'd1080;

  // One paint command.
  typedef struct packed {
    logic                      first_of_frame;
    logic signed [COORD_W-1:0] bounds_x;
    logic signed [COORD_W-1:0] bounds_y;
    logic signed [COORD_W-1:0] bounds_w;
    logic signed [COORD_W-1:0] bounds_h;
    logic signed [COORD_W-1:0] clip_x;
    logic signed [COORD_W-1:0] clip_y;
    logic signed [COORD_W-1:0] clip_w;
    logic signed [COORD_W-1:0] clip_h;
    logic [TEX_W-1:0]          texture;
  } cmd_t;

  // Culled and scaled command handed to the batch stage.
  typedef struct packed {
    logic             valid;
    logic             first_of_frame;
    logic             kept;
    logic [TEX_W-1:0] texture;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] width;
    logic [PIX_W-1:0] height;
  } scissor_t;

  // One result word.
  typedef struct packed {
    logic              kept;
    logic              starts_batch;
    logic [CNT_W-1:0]  command_number;
    logic [CNT_W-1:0]  instance_slot;
    logic [CNT_W-1:0]  batch_number;
    logic [PIX_W-1:0]  scissor_x;
    logic [PIX_W-1:0]  scissor_y;
    logic [PIX_W-1:0]  scissor_w;
    logic [PIX_W-1:0]  scissor_h;
    logic [TEX_W-1:0]  batch_texture;
    logic [CNT_W-1:0]  batch_first;
    logic [SIZE_W-1:0] batch_size;
  } result_t;

  // Sign extension of a coordinate to edge width.
  function automatic logic signed [EDGE_W-1:0] sext_coord(input logic signed [COORD_W-1:0] v);
    return {v[COORD_W-1], v};
  endfunction

endpackage

[sv/draw_command_cull_and_batch_top.sv]
`timescale 1ns / 1ps

// Draw command cull and batch.
// The slave stream takes one paint command per word: bounds and clip
// rectangles in signed Q16.8 and a texture handle, with the frame-start flag
// in s_tuser. The master stream returns exactly one word per command: whether
// it was kept, whether it opened a new batch, its counters and the scissor,
// texture, first slot and size of the batch it joined.
// The configuration channel writes the DPI scale and the frame size; it is
// always ready. The user must write it only while no command is in flight;
// the block does not enforce this. An accepted command passes the input
// register, edge sums, four parallel scale multiplies and the scissor
// register, then the batch logic writes it to the 8-word result queue that
// drives m_tvalid. Throughput is one word per cycle while s_tready is high.
// Batch state updates per command; each sees the batch left by the one before.
// s_tready drops when 8 words are in the pipeline or waiting in the queue,
// so a stalled receiver holds the queue contents and never loses a word.
// Synchronous reset empties the pipeline and queue, clears the counters and
// the open batch, and restores the reset configuration.
module draw_command_cull_and_batch_top
  import dccb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // bounds_x, bounds_y, bounds_w, bounds_h, clip_x, clip_y, clip_w, clip_h, texture
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // first_of_frame
  input  logic [0:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // command_number, instance_slot, batch_number, scissor_x, scissor_y, scissor_w,
  // scissor_h, batch_texture, batch_first, batch_size, zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  // kept, starts_batch
  output logic [1:0]            m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [SCALE_W-1:0]    cfg_data
);

  logic [SCALE_W-1:0] dpi_scale;
  logic [PIX_W-1:0]   frame_width, frame_height;
  logic               in_acc, out_acc;
  logic [QPTR_W:0]    occupancy;
  cmd_t               cmd;
  scissor_t           sc;
  logic               res_valid;
  result_t            res, head;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dpi_scale    <= DPI_SCALE_RESET;
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DPI_SCALE:    dpi_scale    <= cfg_data;
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[PIX_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[PIX_W-1:0];
        default:          ;
      endcase
    end
  end

  // Credit count over the pipeline and the result queue.
  assign in_acc   = s_tvalid && s_tready;
  assign out_acc  = m_tvalid && m_tready;
  assign s_tready = (occupancy != (QPTR_W + 1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else begin
      occupancy <= occupancy + (QPTR_W + 1)'(in_acc) - (QPTR_W + 1)'(out_acc);
    end
  end

  // Input word unpacking.
  always_comb begin
    cmd.first_of_frame = s_tuser[0];
    cmd.bounds_x       = s_tdata[23:0];
    cmd.bounds_y       = s_tdata[47:24];
    cmd.bounds_w       = s_tdata[71:48];
    cmd.bounds_h       = s_tdata[95:72];
    cmd.clip_x         = s_tdata[119:96];
    cmd.clip_y         = s_tdata[143:120];
    cmd.clip_w         = s_tdata[167:144];
    cmd.clip_h         = s_tdata[191:168];
    cmd.texture        = s_tdata[207:192];
  end

  dccb_geom u_geom (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_acc),
    .in_cmd       (cmd),
    .dpi_scale    (dpi_scale),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .out_sc       (sc)
  );

  dccb_batch u_batch (
    .clk       (clk),
    .rst       (rst),
    .sc        (sc),
    .res_valid (res_valid),
    .res       (res)
  );

  dccb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_valid),
    .wr_data  (res),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_data  (head)
  );

  // Output word packing.
  always_comb begin
    m_tuser          = {head.starts_batch, head.kept};
    m_tdata          = '0;
    m_tdata[15:0]    = head.command_number;
    m_tdata[31:16]   = head.instance_slot;
    m_tdata[47:32]   = head.batch_number;
    m_tdata[62:48]   = head.scissor_x;
    m_tdata[77:63]   = head.scissor_y;
    m_tdata[92:78]   = head.scissor_w;
    m_tdata[107:93]  = head.scissor_h;
    m_tdata[123:108] = head.batch_texture;
    m_tdata[139:124] = head.batch_first;
    m_tdata[156:140] = head.batch_size;
  end

endmodule

[sv/dccb_geom.sv]
`timescale 1ns / 1ps

module dccb_geom
  import dccb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  cmd_t               in_cmd,
  input  logic [SCALE_W-1:0] dpi_scale,
  input  logic [PIX_W-1:0]   frame_width,
  input  logic [PIX_W-1:0]   frame_height,
  output scissor_t           out_sc
);

  // Stage 0: input register.
  logic v0;
  cmd_t c0;

  // Stage 1: overlap test and clip edges.
  logic                     v1, fof1, hit1;
  logic [TEX_W-1:0]         tex1;
  logic signed [EDGE_W-1:0] el1, et1, er1, eb1;

  // Stage 2: scaled edges.
  logic                     v2, fof2, hit2;
  logic [TEX_W-1:0]         tex2;
  logic signed [PROD_W-1:0] pl2, pt2, pr2, pb2;

  logic signed [EDGE_W-1:0] bx, by, bw, bh, cx, cy, cw, ch;
  logic signed [EDGE_W-1:0] b_right, b_bottom, c_right, c_bottom;
  logic                     hit_next;
  logic signed [SCALE_W:0]  scale_s;
  logic [PIX_W-1:0]         left, top, right, bottom, sw, sh;
  logic                     kept_next;

  // Left or top edge: zero when negative, else floor, then clamp.
  function automatic logic [PIX_W-1:0] floor_px(input logic signed [PROD_W-1:0] p,
                                                input logic [PIX_W-1:0] limit);
    logic [INT_W-1:0] f;
    f = p[PROD_W-1:PIX_FRAC_BITS];
    if (p[PROD_W-1]) begin
      return '0;
    end else if (f > INT_W'(limit)) begin
      return limit;
    end else begin
      return f[PIX_W-1:0];
    end
  endfunction

  // Right or bottom edge: zero when not positive, else ceiling, then clamp.
  function automatic logic [PIX_W-1:0] ceil_px(input logic signed [PROD_W-1:0] p,
                                               input logic [PIX_W-1:0] limit);
    logic [INT_W:0] c;
    c = {1'b0, p[PROD_W-1:PIX_FRAC_BITS]} + (INT_W + 1)'(|p[PIX_FRAC_BITS-1:0]);
    if (p[PROD_W-1] || p == '0) begin
      return '0;
    end else if (c > (INT_W + 1)'(limit)) begin
      return limit;
    end else begin
      return c[PIX_W-1:0];
    end
  endfunction

  // Overlap test on the registered command.
  always_comb begin
    bx       = sext_coord(c0.bounds_x);
    by       = sext_coord(c0.bounds_y);
    bw       = sext_coord(c0.bounds_w);
    bh       = sext_coord(c0.bounds_h);
    cx       = sext_coord(c0.clip_x);
    cy       = sext_coord(c0.clip_y);
    cw       = sext_coord(c0.clip_w);
    ch       = sext_coord(c0.clip_h);
    b_right  = bx + bw;
    b_bottom = by + bh;
    c_right  = cx + cw;
    c_bottom = cy + ch;
    hit_next = (bw > 0) && (bh > 0) && (cw > 0) && (ch > 0) &&
               (bx < c_right) && (cx < b_right) &&
               (by < c_bottom) && (cy < b_bottom);
  end

  assign scale_s = $signed({1'b0, dpi_scale});

  // Pixel scissor from the scaled edges.
  always_comb begin
    left      = floor_px(pl2, frame_width);
    top       = floor_px(pt2, frame_height);
    right     = ceil_px(pr2, frame_width);
    bottom    = ceil_px(pb2, frame_height);
    sw        = (right > left) ? right - left : '0;
    sh        = (bottom > top) ? bottom - top : '0;
    kept_next = hit2 && (sw != '0) && (sh != '0);
  end

  // Stage registers; only the valid bits are reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0           <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      out_sc.valid <= 1'b0;
    end else begin
      v0           <= in_valid;
      v1           <= v0;
      v2           <= v1;
      out_sc.valid <= v2;
    end
    c0                    <= in_cmd;
    fof1                  <= c0.first_of_frame;
    tex1                  <= c0.texture;
    hit1                  <= hit_next;
    el1                   <= cx;
    et1                   <= cy;
    er1                   <= c_right;
    eb1                   <= c_bottom;
    fof2                  <= fof1;
    tex2                  <= tex1;
    hit2                  <= hit1;
    pl2                   <= el1 * scale_s;
    pt2                   <= et1 * scale_s;
    pr2                   <= er1 * scale_s;
    pb2                   <= eb1 * scale_s;
    out_sc.first_of_frame <= fof2;
    out_sc.texture        <= tex2;
    out_sc.kept           <= kept_next;
    out_sc.left           <= left;
    out_sc.top            <= top;
    out_sc.width          <= sw;
    out_sc.height         <= sh;
  end

endmodule

[sv/dccb_batch.sv]
`timescale 1ns / 1ps

module dccb_batch
  import dccb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  scissor_t sc,
  output logic     res_valid,
  output result_t  res
);

  localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(MAX_COMMANDS);

  logic [CNT_W-1:0]  command_count;
  logic [CNT_W-1:0]  instance_count;
  logic              batch_open;
  logic [CNT_W-1:0]  batch_index;
  logic [PIX_W-1:0]  open_scissor_x, open_scissor_y, open_scissor_w, open_scissor_h;
  logic [TEX_W-1:0]  open_texture;
  logic [CNT_W-1:0]  open_first;
  logic [SIZE_W-1:0] open_size;

  logic [CNT_W-1:0]  cmd_no, slot, next_index;
  logic              open_now, match;
  logic [SIZE_W-1:0] size_inc;

  // A frame start clears the counters and closes the open batch first.
  always_comb begin
    cmd_no     = sc.first_of_frame ? '0 : command_count;
    slot       = sc.first_of_frame ? '0 : instance_count;
    open_now   = batch_open && !sc.first_of_frame;
    next_index = open_now ? batch_index + 1'b1 : '0;
    match      = open_now && (sc.texture == open_texture) &&
                 (sc.left == open_scissor_x) && (sc.top == open_scissor_y) &&
                 (sc.width == open_scissor_w) && (sc.height == open_scissor_h);
    size_inc   = (open_size == SIZE_LIMIT) ? open_size : open_size + 1'b1;
  end

  // Result word; a dropped command reports only its position.
  always_comb begin
    res                = '0;
    res.command_number = cmd_no;
    if (sc.kept) begin
      res.kept          = 1'b1;
      res.starts_batch  = !match;
      res.instance_slot = slot;
      res.batch_number  = match ? batch_index : next_index;
      res.scissor_x     = sc.left;
      res.scissor_y     = sc.top;
      res.scissor_w     = sc.width;
      res.scissor_h     = sc.height;
      res.batch_texture = sc.texture;
      res.batch_first   = match ? open_first : slot;
      res.batch_size    = match ? size_inc : SIZE_W'(1);
    end
  end

  assign res_valid = sc.valid;

  // Counters and batch state.
  always_ff @(posedge clk) begin
    if (rst) begin
      command_count  <= '0;
      instance_count <= '0;
      batch_open     <= 1'b0;
      batch_index    <= '0;
    end else if (sc.valid) begin
      command_count <= cmd_no + 1'b1;
      if (sc.kept) begin
        instance_count <= slot + 1'b1;
        batch_open     <= 1'b1;
        batch_index    <= res.batch_number;
      end else if (sc.first_of_frame) begin
        instance_count <= '0;
        batch_open     <= 1'b0;
        batch_index    <= '0;
      end
    end
  end

  // Open batch description, only read while a batch is open.
  always_ff @(posedge clk) begin
    if (sc.valid && sc.kept) begin
      open_scissor_x <= res.scissor_x;
      open_scissor_y <= res.scissor_y;
      open_scissor_w <= res.scissor_w;
      open_scissor_h <= res.scissor_h;
      open_texture   <= res.batch_texture;
      open_first     <= res.batch_first;
      open_size      <= res.batch_size;
    end
  end

endmodule

[sv/dccb_queue.sv]
`timescale 1ns / 1ps

module dccb_queue
  import dccb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  result_t wr_data,
  output logic    rd_valid,
  input  logic    rd_ready,
  output result_t rd_data
);

  result_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              rd_en;

  assign rd_valid = (count != '0);
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W + 1)'(wr_en) - (QPTR_W + 1)'(rd_en);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

[sv/dccb_checker.sv]
`timescale 1ns / 1ps

module dccb_checker
  import dccb_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]            m_tuser
);

  // The queue is empty and the input is open right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("result word shown or input closed right after reset");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  // A dropped command carries nothing but its position.
  a_dropped: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tuser[0] |-> !m_tuser[1] && m_tdata[156:16] == '0)
    else $error("dropped command carries batch fields");

  // A new batch always holds exactly this command.
  a_new_batch: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tuser[1] |-> m_tdata[156:140] == 17'd1 &&
                                 m_tdata[139:124] == m_tdata[31:16])
    else $error("new batch size or first slot wrong");

endmodule

bind draw_command_cull_and_batch_top dccb_checker u_dccb_checker (.*);
